@@ sv/gphm_pkg.sv @@
// ----------------------------------------------------------------------------
// gphm_pkg
// Shared types and codes for the ground plane homography mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package gphm_pkg;

    localparam int QW = 33;

    // coefficient fraction bits; the scale cancels in the divide
    localparam int H_FRAC_BITS    = 8;
    localparam int HINV_FRAC_BITS = 18;

    typedef enum logic [0:0] {
        OP_G2I = 1'b0,
        OP_I2G = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_H_ROW0    = 3'd0,
        REG_H_ROW1    = 3'd1,
        REG_H_ROW2    = 3'd2,
        REG_HINV_ROW0 = 3'd3,
        REG_HINV_ROW1 = 3'd4,
        REG_HINV_ROW2 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic op;
        logic neg_u;
        logic neg_v;
        logic zero;
        logic ovf_u;
        logic ovf_v;
    } side_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } sat_res_t;

endpackage

`default_nettype wire

@@ sv/ground_plane_homography_mapper.sv @@
// ----------------------------------------------------------------------------
// ground_plane_homography_mapper
// Maps points between ground plane and image through a loaded homography
// or its inverse, with a pipelined divide, rounding and saturation.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// s_        in         s_valid / s_ready     operation, point coordinates
// m_        out        m_valid / m_ready     pixel or ground point, status
// cfg_      in         cfg_valid / cfg_ready register index, row data
//
// one transaction per cycle while the output register is empty or taken.
// stages: multiply, sum, magnitude, a one bit per stage restoring
// divider, one output register. the whole pipeline advances while the
// output register is empty or taken. reset clears valid bits and matrix
// registers; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module ground_plane_homography_mapper #(
    parameter int COEF_WIDTH       = 21,
    parameter int GROUND_FRAC_BITS = 16
) (
    input  wire          aclk,
    input  wire          aresetn,

    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [2:0]   cfg_addr,
    input  wire  [62:0]  cfg_data,

    input  wire          s_valid,
    output logic         s_ready,
    input  wire          s_operation,
    input  wire  [31:0]  s_ground_x,
    input  wire  [31:0]  s_ground_y,
    input  wire  [15:0]  s_pixel_col,
    input  wire  [15:0]  s_pixel_row,

    output logic         m_valid,
    input  wire          m_ready,
    output logic [15:0]  m_col_out,
    output logic [15:0]  m_row_out,
    output logic [31:0]  m_ground_x_out,
    output logic [31:0]  m_ground_y_out,
    output logic [1:0]   m_status
);

    localparam int CW  = COEF_WIDTH;
    localparam int GF  = GROUND_FRAC_BITS;
    localparam int QW  = gphm_pkg::QW;
    localparam int RWW = 3 * CW;
    localparam int AW  = 32 + CW;
    localparam int CWC = CW + GF + 1;
    localparam int SW  = AW + 2;
    localparam int NW  = SW + GF;
    localparam int RW  = NW + 2;
    localparam int DW  = SW + 1;
    localparam int XW  = RW + QW;

    // configuration
    logic [RWW-1:0] row_reg [0:5];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                row_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                gphm_pkg::REG_H_ROW0:    row_reg[0] <= cfg_data[RWW-1:0];
                gphm_pkg::REG_H_ROW1:    row_reg[1] <= cfg_data[RWW-1:0];
                gphm_pkg::REG_H_ROW2:    row_reg[2] <= cfg_data[RWW-1:0];
                gphm_pkg::REG_HINV_ROW0: row_reg[3] <= cfg_data[RWW-1:0];
                gphm_pkg::REG_HINV_ROW1: row_reg[4] <= cfg_data[RWW-1:0];
                gphm_pkg::REG_HINV_ROW2: row_reg[5] <= cfg_data[RWW-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: products
    logic                  vld1_reg;
    logic                  op1_reg;
    logic signed [AW-1:0]  pa_reg [0:2];
    logic signed [AW-1:0]  pb_reg [0:2];
    logic signed [CWC-1:0] pc_reg [0:2];

    logic                  in_op;
    logic signed [31:0]    in_a;
    logic signed [31:0]    in_b;
    logic [RWW-1:0]        sel_row [0:2];

    always_comb begin
        in_op = s_operation;
        if (in_op == gphm_pkg::OP_I2G) begin
            in_a = 32'($signed(s_pixel_col));
            in_b = 32'($signed(s_pixel_row));
            for (int r = 0; r < 3; r++) begin
                sel_row[r] = row_reg[3 + r];
            end
        end else begin
            in_a = $signed(s_ground_x);
            in_b = $signed(s_ground_y);
            for (int r = 0; r < 3; r++) begin
                sel_row[r] = row_reg[r];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= in_op;
            for (int r = 0; r < 3; r++) begin
                pa_reg[r] <= AW'(in_a) * AW'($signed(sel_row[r][CW-1:0]));
                pb_reg[r] <= AW'(in_b) * AW'($signed(sel_row[r][2*CW-1:CW]));
                if (in_op == gphm_pkg::OP_I2G) begin
                    pc_reg[r] <= CWC'($signed(sel_row[r][3*CW-1:2*CW]));
                end else begin
                    pc_reg[r] <= CWC'($signed(sel_row[r][3*CW-1:2*CW])) <<< GF;
                end
            end
        end
    end

    // stage 2: dot products
    logic                 vld2_reg;
    logic                 op2_reg;
    logic signed [SW-1:0] dot_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg <= op1_reg;
            for (int r = 0; r < 3; r++) begin
                dot_reg[r] <= SW'(pa_reg[r]) + SW'(pb_reg[r]) + SW'(pc_reg[r]);
            end
        end
    end

    // stage 3: magnitudes, dividend and divisor, overflow precheck
    logic [RW-1:0]       ru_reg   [0:QW-1];
    logic [RW-1:0]       rv_reg   [0:QW-1];
    logic [QW-1:0]       qu_reg   [0:QW];
    logic [QW-1:0]       qv_reg   [0:QW];
    logic [DW-1:0]       d_reg    [0:QW-1];
    gphm_pkg::side_t     side_reg [0:QW];
    logic                vld_reg  [0:QW];

    logic [SW-1:0] mag_u;
    logic [SW-1:0] mag_v;
    logic [SW-1:0] mag_w;
    logic [NW-1:0] n_u;
    logic [NW-1:0] n_v;
    logic [RW-1:0] num_u_next;
    logic [RW-1:0] num_v_next;
    logic [DW-1:0] den_next;
    logic [XW-1:0] den_top;
    gphm_pkg::side_t side_next;

    always_comb begin
        mag_u = dot_reg[0][SW-1] ? SW'(-dot_reg[0]) : SW'(dot_reg[0]);
        mag_v = dot_reg[1][SW-1] ? SW'(-dot_reg[1]) : SW'(dot_reg[1]);
        mag_w = dot_reg[2][SW-1] ? SW'(-dot_reg[2]) : SW'(dot_reg[2]);
        if (op2_reg == gphm_pkg::OP_I2G) begin
            n_u = NW'(mag_u) << GF;
            n_v = NW'(mag_v) << GF;
        end else begin
            n_u = NW'(mag_u);
            n_v = NW'(mag_v);
        end
        num_u_next = (RW'(n_u) << 1) + RW'(mag_w);
        num_v_next = (RW'(n_v) << 1) + RW'(mag_w);
        den_next   = DW'(mag_w) << 1;
        den_top    = XW'(den_next) << QW;
        side_next.op    = op2_reg;
        side_next.neg_u = dot_reg[0][SW-1] ^ dot_reg[2][SW-1];
        side_next.neg_v = dot_reg[1][SW-1] ^ dot_reg[2][SW-1];
        side_next.zero  = (dot_reg[2] == '0);
        side_next.ovf_u = (XW'(num_u_next) >= den_top);
        side_next.ovf_v = (XW'(num_v_next) >= den_top);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ru_reg[0]   <= num_u_next;
            rv_reg[0]   <= num_v_next;
            qu_reg[0]   <= '0;
            qv_reg[0]   <= '0;
            d_reg[0]    <= den_next;
            side_reg[0] <= side_next;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int B = QW - 1 - k;
        logic [XW-1:0] dsh;
        logic          ge_u;
        logic          ge_v;

        assign dsh  = XW'(d_reg[k]) << B;
        assign ge_u = (XW'(ru_reg[k]) >= dsh);
        assign ge_v = (XW'(rv_reg[k]) >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qu_reg[k+1]   <= qu_reg[k] | (QW'(ge_u) << B);
                qv_reg[k+1]   <= qv_reg[k] | (QW'(ge_v) << B);
                side_reg[k+1] <= side_reg[k];
            end
        end

        // remainder and divisor are not needed after the last bit
        if (k < QW - 1) begin : g_rem
            logic [XW-1:0] du;
            logic [XW-1:0] dv;

            assign du = XW'(ru_reg[k]) - dsh;
            assign dv = XW'(rv_reg[k]) - dsh;

            always_ff @(posedge aclk) begin
                if (en) begin
                    ru_reg[k+1] <= ge_u ? du[RW-1:0] : ru_reg[k];
                    rv_reg[k+1] <= ge_v ? dv[RW-1:0] : rv_reg[k];
                    d_reg[k+1]  <= d_reg[k];
                end
            end
        end
    end

    // rounding already folded in; sign and clamp
    function automatic gphm_pkg::sat_res_t clamp(
        input logic [QW-1:0] q,
        input logic          ovf,
        input logic          neg,
        input logic          op
    );
        gphm_pkg::sat_res_t res;
        logic [QW-1:0]      lim;
        logic [QW-1:0]      negq;
        lim  = (op == gphm_pkg::OP_I2G) ? (QW'(1) << 31) : (QW'(1) << 15);
        negq = QW'(0) - q;
        if (!ovf && q == '0) begin
            res.sat = 1'b0;
            res.val = '0;
        end else if (neg) begin
            res.sat = ovf || (q > lim);
            res.val = res.sat ? 32'(QW'(0) - lim) : negq[31:0];
        end else begin
            res.sat = ovf || (q >= lim);
            res.val = res.sat ? 32'(lim - QW'(1)) : q[31:0];
        end
        return res;
    endfunction

    gphm_pkg::side_t    fin_side;
    gphm_pkg::sat_res_t res_u;
    gphm_pkg::sat_res_t res_v;

    assign fin_side = side_reg[QW];
    assign res_u = clamp(qu_reg[QW], fin_side.ovf_u, fin_side.neg_u, fin_side.op);
    assign res_v = clamp(qv_reg[QW], fin_side.ovf_v, fin_side.neg_v, fin_side.op);

    // output register
    logic [15:0] col_reg;
    logic [15:0] row_out_reg;
    logic [31:0] gx_reg;
    logic [31:0] gy_reg;
    logic [1:0]  status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            col_reg     <= '0;
            row_out_reg <= '0;
            gx_reg      <= '0;
            gy_reg      <= '0;
            if (fin_side.zero) begin
                status_reg <= gphm_pkg::ST_ZERO;
            end else begin
                status_reg <= (res_u.sat || res_v.sat) ? gphm_pkg::ST_SAT
                                                        : gphm_pkg::ST_OK;
                if (fin_side.op == gphm_pkg::OP_I2G) begin
                    gx_reg <= res_u.val;
                    gy_reg <= res_v.val;
                end else begin
                    col_reg     <= res_u.val[15:0];
                    row_out_reg <= res_v.val[15:0];
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_col_out      = col_reg;
    assign m_row_out      = row_out_reg;
    assign m_ground_x_out = gx_reg;
    assign m_ground_y_out = gy_reg;
    assign m_status       = status_reg;

`ifndef ASSERT_OFF
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == gphm_pkg::ST_OK || m_status == gphm_pkg::ST_ZERO
                     || m_status == gphm_pkg::ST_SAT))
        else $error("illegal status code");

    a_zero_div_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == gphm_pkg::ST_ZERO) |->
            (m_col_out == '0 && m_row_out == '0 && m_ground_x_out == '0
             && m_ground_y_out == '0))
        else $error("zero divisor result not cleared");

    a_one_direction: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_col_out != '0 || m_row_out != '0)) |->
            (m_ground_x_out == '0 && m_ground_y_out == '0))
        else $error("both pixel and ground fields set");
`endif

endmodule

`default_nettype wire

@@ tb/tb_ground_plane_homography_mapper.sv @@
// ----------------------------------------------------------------------------
// tb_ground_plane_homography_mapper
// Self-checking bench for the homography point mapper: loads several matrix sets,
// drives directed and random points in both directions with random idling on
// both channels, and checks every result against a local predictor or a fixed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ground_plane_homography_mapper;

    localparam int CW      = 21;
    localparam int GFRAC   = 16;
    localparam int LATENCY = 37;
    localparam int WD_MAX  = 2000;

    typedef struct {
        logic [15:0]       col;
        logic [15:0]       row;
        logic [31:0]       gx;
        logic [31:0]       gy;
        gphm_pkg::status_t st;
    } point_res_t;

    typedef struct {
        gphm_pkg::op_t op;
        logic [31:0]   gx;
        logic [31:0]   gy;
        logic [15:0]   pc;
        logic [15:0]   pr;
        bit            fixed;
        point_res_t    res;
    } point_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic [2:0]  cfg_addr = '0;
    logic [62:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic        s_operation = 1'b0;
    logic [31:0] s_ground_x = '0;
    logic [31:0] s_ground_y = '0;
    logic [15:0] s_pixel_col = '0;
    logic [15:0] s_pixel_row = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [15:0] m_col_out;
    wire  [15:0] m_row_out;
    wire  [31:0] m_ground_x_out;
    wire  [31:0] m_ground_y_out;
    wire  [1:0]  m_status;

    logic [62:0] matrix_regs [6];
    point_res_t  pending_points [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          out_hold = 0;
    bit          no_stall = 1'b0;

    ground_plane_homography_mapper i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_ground_x(s_ground_x), .s_ground_y(s_ground_y),
        .s_pixel_col(s_pixel_col), .s_pixel_row(s_pixel_row),
        .m_valid(m_valid), .m_ready(m_ready), .m_col_out(m_col_out),
        .m_row_out(m_row_out), .m_ground_x_out(m_ground_x_out),
        .m_ground_y_out(m_ground_y_out), .m_status(m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint coef_of(int r, int k);
        logic [CW-1:0] c;
        c = matrix_regs[r][k*CW +: CW];
        return longint'(signed'(c));
    endfunction

    // rounded, saturated quotient of (num << sh) / den; returns 1 when clamped
    function automatic bit round_div(longint num, longint den, int sh, int bits,
                                     output longint q_out);
        logic [63:0] n, d, q, lim;
        bit neg;
        n = (num < 0 ? -num : num);
        n = n << sh;
        d = (den < 0 ? -den : den);
        neg = (num < 0) != (den < 0);
        q = (2 * n + d) / (2 * d);
        lim = 64'd1 << (bits - 1);
        q_out = 0;
        if (q == 0) return 1'b0;
        if (neg) begin
            if (q > lim) begin
                q_out = -longint'(lim);
                return 1'b1;
            end
            q_out = -longint'(q);
            return 1'b0;
        end
        if (q > lim - 1) begin
            q_out = longint'(lim - 1);
            return 1'b1;
        end
        q_out = longint'(q);
        return 1'b0;
    endfunction

    function automatic point_res_t map_point(gphm_pkg::op_t op, logic [31:0] gx,
                                             logic [31:0] gy, logic [15:0] pc,
                                             logic [15:0] pr);
        point_res_t res;
        longint a, b, one, u, v, w, q0, q1;
        int base, sh, bits;
        bit s0, s1;
        res = '{default: '0, st: gphm_pkg::ST_OK};
        q0 = 0;
        q1 = 0;
        if (op == gphm_pkg::OP_G2I) begin
            a = longint'(signed'(gx));
            b = longint'(signed'(gy));
            one = longint'(1) << GFRAC;
            base = 0; sh = 0; bits = 16;
        end else begin
            a = longint'(signed'(pc));
            b = longint'(signed'(pr));
            one = 1;
            base = 3; sh = GFRAC; bits = 32;
        end
        u = coef_of(base, 0) * a + coef_of(base, 1) * b + coef_of(base, 2) * one;
        v = coef_of(base+1, 0) * a + coef_of(base+1, 1) * b + coef_of(base+1, 2) * one;
        w = coef_of(base+2, 0) * a + coef_of(base+2, 1) * b + coef_of(base+2, 2) * one;
        if (w == 0) begin
            res.st = gphm_pkg::ST_ZERO;
        end else begin
            s0 = round_div(u, w, sh, bits, q0);
            s1 = round_div(v, w, sh, bits, q1);
            if (s0 || s1) res.st = gphm_pkg::ST_SAT;
        end
        if (op == gphm_pkg::OP_G2I) begin
            res.col = q0[15:0];
            res.row = q1[15:0];
        end else begin
            res.gx = q0[31:0];
            res.gy = q1[31:0];
        end
        return res;
    endfunction

    function automatic logic [62:0] pack_row(longint c0, longint c1, longint c2);
        logic [62:0] r;
        r = 63'({$urandom, $urandom});
        r[CW-1:0] = c0[CW-1:0];
        r[2*CW-1:CW] = c1[CW-1:0];
        r[3*CW-1:2*CW] = c2[CW-1:0];
        return r;
    endfunction

    function automatic void add_expected(point_res_t res);
        pending_points.insert(pending_points.size(), res);
    endfunction

    task automatic write_reg(gphm_pkg::reg_idx_t idx, logic [62:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        matrix_regs[idx] = data;
        @(negedge aclk);
    endtask

    task automatic load_matrices(logic [62:0] m [6]);
        for (int i = 0; i < 6; i++) write_reg(gphm_pkg::reg_idx_t'(i), m[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_points.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic send_point(gphm_pkg::op_t op, logic [31:0] gx, logic [31:0] gy,
                              logic [15:0] pc, logic [15:0] pr, bit fixed,
                              point_res_t fixed_res);
        if (!no_stall && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_ground_x  <= gx;
        s_ground_y  <= gy;
        s_pixel_col <= pc;
        s_pixel_row <= pr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        add_expected(fixed ? fixed_res : map_point(op, gx, gy, pc, pr));
        @(negedge aclk);
    endtask

    task automatic finish_burst;
        s_valid <= 1'b0;
    endtask

    task automatic random_points(int n, int g_range, int p_range);
        gphm_pkg::op_t op;
        logic [31:0] gx, gy;
        point_res_t dummy;
        dummy = '{default: '0, st: gphm_pkg::ST_OK};
        for (int i = 0; i < n; i++) begin
            op = gphm_pkg::op_t'($urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) begin
                gx = $urandom;
                gy = $urandom;
            end else begin
                gx = $signed($urandom_range(0, 2 * g_range)) - g_range;
                gy = $signed($urandom_range(0, 2 * g_range)) - g_range;
            end
            send_point(op, gx, gy,
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                           : 16'($signed($urandom_range(0, 2 * p_range)) - p_range),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom)
                           : 16'($signed($urandom_range(0, 2 * p_range)) - p_range),
                       1'b0, dummy);
        end
        finish_burst();
    endtask

    // a camera looking down at the ground: plausible matrices with small jitter
    task automatic camera_matrices(output logic [62:0] m [6]);
        longint j;
        j = $urandom_range(0, 40);
        m[0] = pack_row(256 + j, 12, 80000);
        m[1] = pack_row(-5, 200 + j, 60000);
        m[2] = pack_row(0, 3 + j / 10, 256);
        m[3] = pack_row(262144 - 4 * j, -300, -20000);
        m[4] = pack_row(700, 262144 + j, -15000);
        m[5] = pack_row(0, 40 + j, 9000);
    endtask

    task automatic random_matrices(output logic [62:0] m [6]);
        for (int i = 0; i < 6; i++) m[i] = 63'({$urandom, $urandom});
    endtask

    initial begin
        point_row_t  dir_rows [$];
        logic [62:0] m [6];
        point_res_t  zero_res, zero_div;

        zero_res = '{default: '0, st: gphm_pkg::ST_OK};
        zero_div = '{default: '0, st: gphm_pkg::ST_ZERO};
        for (int i = 0; i < 6; i++) matrix_regs[i] = '0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // after reset every matrix is zero, so every divisor is zero
        send_point(gphm_pkg::OP_G2I, 32'h7fffffff, 32'h80000000, '0, '0, 1'b1, zero_div);
        send_point(gphm_pkg::OP_I2G, '0, '0, 16'h8000, 16'h7fff, 1'b1, zero_div);
        finish_burst();
        drain();

        // identity-like H and Hinv, constant term in w: extremes and rounding
        m[0] = pack_row(1, 0, 0);
        m[1] = pack_row(0, 1, 0);
        m[2] = pack_row(0, 0, 1);
        m[3] = pack_row(1, 0, 0);
        m[4] = pack_row(0, 1, 0);
        m[5] = pack_row(0, 0, 1);
        load_matrices(m);
        dir_rows = '{
            '{gphm_pkg::OP_G2I, 32'd0, 32'd0, 16'h0, 16'h0, 1'b1, zero_res},
            '{gphm_pkg::OP_G2I, 32'h0000_8000, 32'hffff_8000, 16'h0, 16'h0, 1'b0,
              zero_res},
            '{gphm_pkg::OP_G2I, 32'h0000_7fff, 32'hffff_8001, 16'h0, 16'h0, 1'b0,
              zero_res},
            '{gphm_pkg::OP_G2I, 32'h7fff_ffff, 32'h0, 16'h0, 16'h0, 1'b1,
              '{16'h7fff, 16'h0, 32'h0, 32'h0, gphm_pkg::ST_SAT}},
            '{gphm_pkg::OP_G2I, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 1'b1,
              '{16'h8000, 16'h0, 32'h0, 32'h0, gphm_pkg::ST_OK}},
            '{gphm_pkg::OP_G2I, 32'h0, 32'h8000_0000, 16'h1234, 16'h5678, 1'b0,
              zero_res},
            '{gphm_pkg::OP_I2G, 32'hdead_beef, 32'h1234_5678, 16'h7fff, 16'h8000, 1'b0,
              zero_res},
            '{gphm_pkg::OP_I2G, 32'h0, 32'h0, 16'h0001, 16'hffff, 1'b1,
              '{16'h0, 16'h0, 32'h0001_0000, 32'hffff_0000, gphm_pkg::ST_OK}},
            '{gphm_pkg::OP_I2G, 32'h0, 32'h0, 16'h0, 16'h0, 1'b1, zero_res},
            '{gphm_pkg::OP_I2G, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'h0, 1'b0,
              zero_res}
        };
        foreach (dir_rows[i])
            send_point(dir_rows[i].op, dir_rows[i].gx, dir_rows[i].gy, dir_rows[i].pc,
                       dir_rows[i].pr, dir_rows[i].fixed, dir_rows[i].res);
        finish_burst();
        drain();

        // extreme coefficients: saturation in both directions and zero divisor
        m[0] = pack_row(-1048576, 1048575, -1048576);
        m[1] = pack_row(1048575, -1048576, 1048575);
        m[2] = pack_row(1, 1, 0);
        m[3] = pack_row(1048575, -1048576, 1048575);
        m[4] = pack_row(-1048576, 1048575, -1048576);
        m[5] = pack_row(1, -1, 0);
        load_matrices(m);
        dir_rows = '{
            '{gphm_pkg::OP_G2I, 32'h0000_0005, 32'hffff_fffb, 16'h0, 16'h0, 1'b1,
              zero_div},
            '{gphm_pkg::OP_G2I, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0, 16'h0, 1'b0,
              zero_res},
            '{gphm_pkg::OP_G2I, 32'h8000_0000, 32'h0000_0001, 16'h0, 16'h0, 1'b0,
              zero_res},
            '{gphm_pkg::OP_I2G, 32'h0, 32'h0, 16'h0007, 16'h0007, 1'b1, zero_div},
            '{gphm_pkg::OP_I2G, 32'h0, 32'h0, 16'h7fff, 16'h8000, 1'b0, zero_res},
            '{gphm_pkg::OP_I2G, 32'h0, 32'h0, 16'h0001, 16'h0000, 1'b0, zero_res}
        };
        foreach (dir_rows[i])
            send_point(dir_rows[i].op, dir_rows[i].gx, dir_rows[i].gy, dir_rows[i].pc,
                       dir_rows[i].pr, dir_rows[i].fixed, dir_rows[i].res);
        finish_burst();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 2) random_matrices(m);
            else camera_matrices(m);
            load_matrices(m);
            random_points(200, 2000000, 2000);
            drain();
        end

        no_stall = 1'b1;
        camera_matrices(m);
        load_matrices(m);
        random_points(230, 4000000, 4000);
        drain();

        if (fail_count == 0) begin
            $display("PASS ground_plane_homography_mapper");
        end else begin
            $display("FAIL ground_plane_homography_mapper");
        end
        $finish;
    end

    // output stalls in random bursts
    always @(negedge aclk) begin
        if (!aresetn || no_stall) begin
            m_ready <= aresetn;
            out_hold = 0;
        end else if (out_hold > 0) begin
            out_hold = out_hold - 1;
            if (out_hold == 0) m_ready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            out_hold = $urandom_range(1, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        point_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: unexpected result col=%h row=%h gx=%h gy=%h st=%0d", $time,
                         m_col_out, m_row_out, m_ground_x_out, m_ground_y_out, m_status);
                fail_count++;
            end else begin
                e = pending_points.pop_front();
                if (m_col_out !== e.col || m_row_out !== e.row
                        || m_ground_x_out !== e.gx || m_ground_y_out !== e.gy
                        || m_status !== e.st) begin
                    $display("%0t: mismatch expected col=%h row=%h gx=%h gy=%h st=%0d",
                             $time, e.col, e.row, e.gx, e.gy, e.st);
                    $display("%0t:          actual   col=%h row=%h gx=%h gy=%h st=%0d",
                             $time, m_col_out, m_row_out, m_ground_x_out,
                             m_ground_y_out, m_status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || (pending_points.size() == 0 && !s_valid && !cfg_valid)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_MAX) begin
                $display("FAIL ground_plane_homography_mapper");
                $finish;
            end
        end
    end

endmodule

@@ ground_plane_homography_mapper.f @@
sv/gphm_pkg.sv
sv/ground_plane_homography_mapper.sv
tb/tb_ground_plane_homography_mapper.sv
